/* design/sco_pkg.sv */
package sco_pkg;

	// phase accumulator and lookup geometry
	localparam int TABLE_BITS = 12;
	localparam int PHASE_BITS = 32;
	localparam int QUARTER_SIZE = 1 << (TABLE_BITS - 2);
	localparam int ROM_ADDR_W = TABLE_BITS - 1;
	localparam int INC_W = 32;
	localparam int SAMPLE_W = 16;

	// register file
	localparam int REG_W = 32;
	localparam int ADDR_W = 4;
	localparam logic [REG_W-1:0] START_INC_RST = 32'd15500;
	localparam logic [REG_W-1:0] SWEEP_STEP_RST = 32'd620;
	localparam logic [REG_W-1:0] INC_LIMIT_RST = 32'd2147420300;

	typedef enum logic [1:0] {
		REG_START_INC  = 2'd0,
		REG_SWEEP_STEP = 2'd1,
		REG_INC_LIMIT  = 2'd2
	} reg_idx_t;

	// request queue between front and back
	localparam int REQ_DEPTH = 2;
	localparam int REQ_PTR_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
	localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [REG_W-1:0] start_inc;
		logic [REG_W-1:0] sweep_step;
		logic [REG_W-1:0] inc_limit;
	} cfg_t;

	// one lookup: mirrored quarter-wave address and sign
	typedef struct packed {
		logic [ROM_ADDR_W-1:0] addr;
		logic                  neg;
	} req_t;

endpackage

/* design/sco_front.sv */
module sco_front import sco_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic restart,
	input  cfg_t cfg,
	input  logic q_full,
	output logic full,
	output logic req_push,
	output req_t req_data
);

	typedef enum logic [1:0] {
		QUAD_FIRST  = 2'd0,
		QUAD_SECOND = 2'd1,
		QUAD_THIRD  = 2'd2,
		QUAD_FOURTH = 2'd3
	} quad_t;

	logic [PHASE_BITS-1:0] phase_q;
	logic [INC_W-1:0]      inc_q;
	logic [PHASE_BITS-1:0] phase_eff;
	logic [INC_W-1:0]      inc_eff;
	logic [INC_W:0]        grown;
	logic [INC_W-1:0]      inc_next;
	logic [TABLE_BITS-1:0] k;
	quad_t                 quad;
	logic [ROM_ADDR_W-1:0] r_ext;
	logic                  accept;

	assign full = q_full;
	assign accept = push && !q_full;
	assign req_push = accept;

	always_comb begin
		phase_eff = restart ? '0 : phase_q;
		inc_eff = restart ? cfg.start_inc : inc_q;
		grown = {1'b0, inc_eff} + {1'b0, cfg.sweep_step};
		// grown value past the limit (33-bit compare) falls back to start
		inc_next = (grown > {1'b0, cfg.inc_limit}) ? cfg.start_inc : grown[INC_W-1:0];
		k = phase_eff[PHASE_BITS-1 -: TABLE_BITS];
		quad = quad_t'(k[TABLE_BITS-1 -: 2]);
		r_ext = {1'b0, k[TABLE_BITS-3:0]};
		req_data.addr = r_ext;
		req_data.neg = 1'b0;
		case (quad)
			QUAD_FIRST: begin
				req_data.addr = r_ext;
				req_data.neg = 1'b0;
			end
			QUAD_SECOND: begin
				req_data.addr = ROM_ADDR_W'(QUARTER_SIZE) - r_ext;
				req_data.neg = 1'b1;
			end
			QUAD_THIRD: begin
				req_data.addr = r_ext;
				req_data.neg = 1'b1;
			end
			QUAD_FOURTH: begin
				req_data.addr = ROM_ADDR_W'(QUARTER_SIZE) - r_ext;
				req_data.neg = 1'b0;
			end
			default: begin
				req_data.addr = r_ext;
				req_data.neg = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q <= START_INC_RST;
		end else if (accept) begin
			phase_q <= phase_eff + PHASE_BITS'(inc_eff);
			inc_q <= inc_next;
		end
	end

endmodule

/* design/sco_req_fifo.sv */
module sco_req_fifo import sco_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	input  logic pop,
	output req_t rdata,
	output logic full,
	output logic empty
);

	req_t                 mem_q [REQ_DEPTH];
	logic [REQ_PTR_W-1:0] wr_ptr_q;
	logic [REQ_PTR_W-1:0] rd_ptr_q;
	logic [REQ_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full = (count_q == REQ_CNT_W'(REQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/sco_back.sv */
module sco_back import sco_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_empty,
	input  req_t    req_data,
	output logic    req_pop,
	input  logic    pop,
	output logic    empty,
	output sample_t sample
);

	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int OCC_W = OUT_CNT_W + 1;
	localparam longint unsigned QuarterTurnQ30 = 64'd1686629713;

	typedef sample_t quarter_rom_t [QUARTER_SIZE+1];

	// floor quotient by restoring long division, used for the table build
	function automatic longint unsigned udiv_floor(longint unsigned num,
			longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-wave cosine in Q14 from a nine-term fixed-point series
	function automatic quarter_rom_t build_quarter_rom();
		quarter_rom_t     rom;
		longint unsigned  ang;
		longint unsigned  x2;
		longint unsigned  term;
		longint unsigned  div;
		longint unsigned  usum;
		longint           sum;
		for (int r = 0; r <= QUARTER_SIZE; r++) begin
			ang = (longint'(r) * QuarterTurnQ30) >> (TABLE_BITS - 2);
			x2 = (ang * ang) >> 30;
			term = 64'd1 << 30;
			sum = longint'(term);
			for (int n = 1; n <= 8; n++) begin
				div = longint'((2 * n - 1) * (2 * n));
				term = udiv_floor((term * x2) >> 30, div);
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			usum = longint'(sum);
			rom[r] = SAMPLE_W'((usum * 64'd16384 + (64'd1 << 29)) >> 30);
		end
		return rom;
	endfunction

	localparam quarter_rom_t QuarterRom = build_quarter_rom();

	sample_t              rom_data_s1;
	logic                 neg_s1;
	logic                 v_s1;
	sample_t              out_mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic [OCC_W-1:0]     occ_after;
	logic                 pop_fire;

	assign empty = (count_q == '0);
	assign pop_fire = pop && !empty;
	assign sample = out_mem_q[rd_ptr_q];

	// room for the read in flight plus a new one, after this cycle's pop
	assign occ_after = OCC_W'(count_q) + OCC_W'(v_s1) - OCC_W'(pop_fire);
	assign req_pop = !req_empty && (occ_after < OCC_W'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (req_pop) begin
			rom_data_s1 <= QuarterRom[req_data.addr];
			neg_s1 <= req_data.neg;
		end
		if (v_s1) begin
			out_mem_q[wr_ptr_q] <= neg_s1 ? -rom_data_s1 : rom_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			v_s1 <= req_pop;
			if (v_s1) begin
				wr_ptr_q <= (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (v_s1 && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !v_s1) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/swept_cosine_oscillator.sv */
// channel   | handshake           | payload
// ----------+---------------------+--------------------------------
// input     | push / full         | restart (1 bit)
// result    | pop / empty         | sample (16 bits signed, Q15)
// config    | psel penable pwrite | paddr (4), pwdata / prdata (32)
//
// one transaction per cycle sustained in each direction while the result side
// keeps popping; the front updates phase and increment in the cycle an item is
// taken, so items chain back to back; a result reaches the result ports after the
// request queue and the registered quarter-wave rom read
// the request queue (2 entries) and the result queue (2 entries) let the front
// keep accepting while results wait; full rises only when both are backed up
// reset clears phase, loads the reset start increment, empties both queues;
// the rom is constant, so there is no clearing pass
module swept_cosine_oscillator import sco_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input queue side
	input  logic              push,
	output logic              full,
	input  logic              restart,
	// result queue side
	output logic              empty,
	input  logic              pop,
	output sample_t           sample,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic req_push;
	req_t req_wdata;
	req_t req_rdata;
	logic req_pop;
	logic req_full;
	logic req_empty;

	// register file: word index in paddr[3:2], low address bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_inc <= START_INC_RST;
			cfg_q.sweep_step <= SWEEP_STEP_RST;
			cfg_q.inc_limit <= INC_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_START_INC: begin
					cfg_q.start_inc <= pwdata;
				end
				REG_SWEEP_STEP: begin
					cfg_q.sweep_step <= pwdata;
				end
				REG_INC_LIMIT: begin
					cfg_q.inc_limit <= pwdata;
				end
				default: begin
					// unmapped word, write dropped
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_START_INC: begin
				prdata = cfg_q.start_inc;
			end
			REG_SWEEP_STEP: begin
				prdata = cfg_q.sweep_step;
			end
			REG_INC_LIMIT: begin
				prdata = cfg_q.inc_limit;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// front: takes the transaction, steps phase and sweep, picks quadrant
	sco_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.restart  (restart),
		.cfg      (cfg_q),
		.q_full   (req_full),
		.full     (full),
		.req_push (req_push),
		.req_data (req_wdata)
	);

	// short queue of lookups between the two halves
	sco_req_fifo u_req_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_push),
		.wdata  (req_wdata),
		.pop    (req_pop),
		.rdata  (req_rdata),
		.full   (req_full),
		.empty  (req_empty)
	);

	// back: rom lookup, sign fixup, result queue
	sco_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_empty (req_empty),
		.req_data  (req_rdata),
		.req_pop   (req_pop),
		.pop       (pop),
		.empty     (empty),
		.sample    (sample)
	);

`ifndef SYNTH
	// back never draws from an empty request queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_pop && req_empty))
		else $error("lookup issued from empty request queue");

	// a lookup written into an empty queue is visible next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req_push && req_empty && !req_full) |=> !req_empty)
		else $error("request queue lost a lookup");

	// half-amplitude cosine never leaves its range
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sample >= -16'sd16384) && (sample <= 16'sd16384))
		else $error("sample out of half-amplitude range");
`endif

endmodule

/* verif/swept_cosine_oscillator_tb.sv */
`timescale 1ns / 100ps

module swept_cosine_oscillator_tb;
	import sco_pkg::*;

	// register index past the end of the map, writes to it must be dropped
	localparam int unsigned UNMAPPED_IDX = 3;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [REG_W-1:0] ALL_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic restart = 1'b0;
	logic empty;
	logic pop = 1'b0;
	sample_t sample;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [REG_W-1:0] pwdata = '0;
	logic [REG_W-1:0] prdata;
	logic pready;

	swept_cosine_oscillator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.restart (restart),
		.empty   (empty),
		.pop     (pop),
		.sample  (sample),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// pending restart flags, one per input transaction still to send
	bit pending_restarts[$];
	// samples the oscillator owes us, oldest first
	sample_t expected_samples[$];

	// full-turn cosine table, built once from the quarter-wave series
	sample_t cos_lut [0:(1 << TABLE_BITS) - 1];

	// predictor state and shadow of the register file
	logic [PHASE_BITS-1:0] phase_acc;
	logic [INC_W-1:0] cur_inc;
	cfg_t shadow_cfg;

	// idle control, set per phase by the stimulus process
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned restarts_sent = 0;
	int unsigned samples_checked = 0;
	int unsigned sweep_wraps = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatch_count = 0;

	// round(16384 * cos(r * quarter turn / QUARTER_SIZE)) by a truncated
	// taylor series in q30, negative sums clamp to zero
	function automatic int quarter_wave_q15(int unsigned r);
		longint unsigned ang;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned n;
		longint acc;
		ang = (64'(r) * 64'd1686629713) >> (TABLE_BITS - 2);
		x2 = (ang * ang) >> 30;
		term = 64'd1 << 30;
		acc = longint'(term);
		for (n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
			if (n[0])
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		return int'((acc * 64'sd16384 + (64'sd1 <<< 29)) >>> 30);
	endfunction

	function automatic void build_cos_lut();
		int unsigned k;
		int unsigned r;
		for (k = 0; k < (1 << TABLE_BITS); k++) begin
			r = k % QUARTER_SIZE;
			// mirror the quarter wave into the other three quadrants
			case (k / QUARTER_SIZE)
				0: cos_lut[k] = sample_t'(quarter_wave_q15(r));
				1: cos_lut[k] = sample_t'(-quarter_wave_q15(QUARTER_SIZE - r));
				2: cos_lut[k] = sample_t'(-quarter_wave_q15(r));
				default: cos_lut[k] = sample_t'(quarter_wave_q15(QUARTER_SIZE - r));
			endcase
		end
	endfunction

	// one accepted request: emit the sample at the current phase, then
	// advance phase and sweep the increment with fallback past the limit
	function automatic void predict_sample(bit rst);
		logic [INC_W:0] grown;
		if (rst) begin
			phase_acc = '0;
			cur_inc = shadow_cfg.start_inc;
		end
		expected_samples.push_back(cos_lut[phase_acc[PHASE_BITS-1 -: TABLE_BITS]]);
		phase_acc = phase_acc + PHASE_BITS'(cur_inc);
		grown = {1'b0, cur_inc} + {1'b0, shadow_cfg.sweep_step};
		if (grown > {1'b0, shadow_cfg.inc_limit}) begin
			cur_inc = shadow_cfg.start_inc;
			sweep_wraps++;
		end else begin
			cur_inc = grown[INC_W-1:0];
		end
	endfunction

	// driver: one transaction per accepted push, random gap bursts between
	// items, restart held stable while full backs us up
	always @(posedge clk or negedge arst_n) begin : driver
		bit sent;
		bit nxt_push;
		bit nxt_restart;
		if (!arst_n) begin
			push <= 1'b0;
			restart <= 1'b0;
		end else begin
			sent = push && !full;
			if (sent) begin
				predict_sample(restart);
				items_sent++;
				if (restart)
					restarts_sent++;
				void'(pending_restarts.pop_front());
			end
			nxt_push = push && !sent;
			nxt_restart = restart;
			if (!nxt_push) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_restarts.size() > 0) begin
					if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
						// start a random gap burst, idle from this cycle on
						gap_left = $urandom_range(4, 0);
					end else begin
						nxt_push = 1'b1;
						nxt_restart = pending_restarts[0];
					end
				end
			end
			push <= nxt_push;
			restart <= nxt_restart;
		end
	end

	// monitor: compare each popped sample against the oldest prediction,
	// with random stall bursts on pop
	always @(posedge clk or negedge arst_n) begin : monitor
		sample_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_samples.size() == 0) begin
					$error("sample: no transaction expected, actual %0d", sample);
					mismatch_count++;
				end else begin
					want = expected_samples.pop_front();
					samples_checked++;
					if (sample !== want) begin
						$error("sample: expected %0d, actual %0d", want, sample);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(4, 0);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still owed",
				cycle_count, expected_samples.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// apb write: setup cycle, then access until pready, shadow updated at completion
	task automatic reg_write(int unsigned idx, logic [REG_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		case (idx)
			REG_START_INC:  shadow_cfg.start_inc = value;
			REG_SWEEP_STEP: shadow_cfg.sweep_step = value;
			REG_INC_LIMIT:  shadow_cfg.inc_limit = value;
			default: ;
		endcase
	endtask

	task automatic program_sweep(logic [REG_W-1:0] start, logic [REG_W-1:0] step,
			logic [REG_W-1:0] limit);
		reg_write(REG_START_INC, start);
		reg_write(REG_SWEEP_STEP, step);
		reg_write(REG_INC_LIMIT, limit);
	endtask

	// wait for every queued request to go in and every sample to come back,
	// then let the pipe settle before touching registers
	task automatic drain();
		while (pending_restarts.size() > 0 || expected_samples.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_directed(bit flags[]);
		foreach (flags[i])
			pending_restarts.push_back(flags[i]);
	endtask

	task automatic queue_random(int unsigned count, int unsigned restart_pct);
		repeat (count)
			pending_restarts.push_back($urandom_range(99) < restart_pct);
	endtask

	initial begin
		build_cos_lut();
		shadow_cfg.start_inc = START_INC_RST;
		shadow_cfg.sweep_step = SWEEP_STEP_RST;
		shadow_cfg.inc_limit = INC_LIMIT_RST;
		phase_acc = '0;
		cur_inc = START_INC_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset state first: no restart on the first items
		gap_pct = 20;
		stall_pct = 20;
		queue_directed('{0, 0, 1, 0, 0});
		drain();

		// quarter-turn steps land on the quadrant boundaries: +1, 0, -1, 0
		program_sweep(32'h4000_0000, '0, ALL_ONES);
		queue_directed('{1, 0, 0, 0, 0});
		drain();

		// one table step short of a quarter, sweeping by one table step
		program_sweep(32'h3FF0_0000, 32'h0010_0000, ALL_ONES);
		queue_directed('{1, 0, 0, 0});
		drain();

		// grown increment equal to the limit is kept, one step more falls back
		program_sweep(32'd100, 32'd50, 32'd200);
		queue_directed('{1, 0, 0, 0, 0});
		drain();

		// sum past 32 bits always exceeds the limit
		program_sweep(ALL_ONES, ALL_ONES, ALL_ONES);
		queue_directed('{1, 0, 0});
		drain();

		// new start value waits for a restart; unmapped write changes nothing
		reg_write(REG_START_INC, 32'h0800_0000);
		reg_write(UNMAPPED_IDX, ALL_ONES);
		queue_directed('{0, 0, 1, 0});
		drain();

		// random part: slow chirp with occasional fallback
		gap_pct = 30;
		stall_pct = 10;
		program_sweep($urandom_range(1 << 24), $urandom_range(1 << 20), $urandom);
		queue_random(110, 4);
		// sender holds off until the oscillator has caught up
		drain();
		queue_random(115, 4);
		drain();

		// fully random registers, no idling on the result side
		stall_pct = 0;
		program_sweep($urandom, $urandom, $urandom);
		queue_random(225, 4);
		drain();

		// zero start, full-scale step, limit at max
		gap_pct = 0;
		stall_pct = 40;
		program_sweep('0, ALL_ONES, ALL_ONES);
		queue_random(225, 4);
		drain();

		// limit zero: every sample falls back to a full-scale start
		gap_pct = 40;
		stall_pct = 30;
		program_sweep(ALL_ONES, '0, '0);
		queue_random(225, 4);
		drain();

		// fast wrap of the sweep through a small limit
		gap_pct = 15;
		stall_pct = 15;
		program_sweep($urandom_range(1 << 16), $urandom_range(1 << 12) + 1,
			$urandom_range(1 << 18));
		queue_random(225, 4);
		drain();

		// back to reset values, full rate both ways to the end
		gap_pct = 0;
		stall_pct = 0;
		program_sweep(START_INC_RST, SWEEP_STEP_RST, INC_LIMIT_RST);
		queue_random(225, 4);
		drain();

		$display("checked %0d samples from %0d requests, %0d with restart",
			samples_checked, items_sent, restarts_sent);
		$display("%0d sweep fallbacks seen across %0d register writes, %0d mismatches",
			sweep_wraps, reg_writes, mismatch_count);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/sco_pkg.sv
design/sco_front.sv
design/sco_req_fifo.sv
design/sco_back.sv
design/swept_cosine_oscillator.sv
verif/swept_cosine_oscillator_tb.sv
